/* design/spi_transfer_sequencer_defines.svh */
// Assertion macros used by the SPI transfer sequencer top level.
`ifndef SPI_TRANSFER_SEQUENCER_DEFINES_SVH
`define SPI_TRANSFER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sts_pkg.sv */
// Types and codes shared by the SPI transfer sequencer modules.
package sts_pkg;

    localparam logic [2:0] REQ_SUBMIT   = 3'd0;
    localparam logic [2:0] REQ_PROCESS  = 3'd1;
    localparam logic [2:0] REQ_COMPLETE = 3'd2;
    localparam logic [2:0] REQ_ERROR    = 3'd3;
    localparam logic [2:0] REQ_ABORT    = 3'd4;

    localparam logic [1:0] OP_SUBMIT  = 2'd0;
    localparam logic [1:0] OP_PROCESS = 2'd1;
    localparam logic [1:0] OP_IRQ     = 2'd2;
    localparam logic [1:0] OP_OTHER   = 2'd3;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_NOT_IDLE = 2'd1;
    localparam logic [1:0] VERDICT_BAD_ARG  = 2'd2;
    localparam logic [1:0] VERDICT_BAD_DMA  = 2'd3;

    localparam logic [2:0] EV_NONE     = 3'b000;
    localparam logic [2:0] EV_COMPLETE = 3'b001;
    localparam logic [2:0] EV_ERROR    = 3'b010;
    localparam logic [2:0] EV_ABORT    = 3'b100;

    localparam logic [1:0] KIND_SUBMIT  = 2'd0;
    localparam logic [1:0] KIND_ENDED   = 2'd1;
    localparam logic [1:0] KIND_STARTED = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    localparam logic [1:0] FIN_NONE      = 2'd0;
    localparam logic [1:0] FIN_COMPLETED = 2'd1;
    localparam logic [1:0] FIN_FAILED    = 2'd2;
    localparam logic [1:0] FIN_TIMED_OUT = 2'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BAD_ARG = 3'd1;
    localparam logic [2:0] ERR_BAD_DMA = 3'd2;
    localparam logic [2:0] ERR_BUSY    = 3'd3;
    localparam logic [2:0] ERR_HAL     = 3'd4;
    localparam logic [2:0] ERR_TIMEOUT = 3'd5;

    localparam logic [1:0] START_OK   = 2'd0;
    localparam logic [1:0] START_BUSY = 2'd1;

    localparam logic [1:0] CNT_COMPLETED = 2'd0;
    localparam logic [1:0] CNT_FAILED    = 2'd1;
    localparam logic [1:0] CNT_TIMED_OUT = 2'd2;
    localparam logic [1:0] CNT_REJECTED  = 2'd3;
    localparam int         CNT_NUM       = 4;

    localparam int         CMDQ_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  verdict;
        logic [2:0]  events;
        logic [7:0]  tag;
        logic [15:0] size;
        logic [31:0] timeout;
        logic [31:0] now_time;
        logic [1:0]  start_status;
        logic        abort_ok;
    } cmd_t;

    typedef struct packed {
        logic [31:0] timeout;
        logic [15:0] size;
        logic [7:0]  tag;
    } qent_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [7:0]  tag;
        logic        accepted;
        logic [1:0]  final_status;
        logic [2:0]  error_code;
        logic [15:0] start_size;
        logic        cs_active;
        logic [31:0] completed_total;
        logic [31:0] failed_total;
        logic [31:0] timed_out_total;
        logic [31:0] rejected_total;
    } rsp_t;

endpackage

/* design/sts_front.sv */
// Front end: accepts request words and classifies them into commands.
module sts_front (
    input  logic          req_valid,
    output logic          req_ready,
    input  logic [2:0]    req_type,
    input  logic [7:0]    tag,
    input  logic          item_idle,
    input  logic          tx_present,
    input  logic          rx_present,
    input  logic [15:0]   xfer_size,
    input  logic [31:0]   timeout_limit,
    input  logic          cs_valid,
    input  logic          dma_ok,
    input  logic [31:0]   now_time,
    input  logic [1:0]    start_status,
    input  logic          abort_ok,
    output logic          push_valid,
    input  logic          push_ready,
    output sts_pkg::cmd_t push_cmd
);
    import sts_pkg::*;

    logic bad_arg;

    assign bad_arg = !tx_present || !rx_present || (xfer_size == 16'd0) ||
                     (timeout_limit == 32'd0) || !cs_valid;

    assign push_valid = req_valid;
    assign req_ready  = push_ready;

    always_comb
    begin
        push_cmd              = '0;
        push_cmd.tag          = tag;
        push_cmd.size         = xfer_size;
        push_cmd.timeout      = timeout_limit;
        push_cmd.now_time     = now_time;
        push_cmd.start_status = start_status;
        push_cmd.abort_ok     = abort_ok;
        push_cmd.events       = EV_NONE;
        push_cmd.op           = OP_OTHER;
        if (!item_idle)
        begin
            push_cmd.verdict = VERDICT_NOT_IDLE;
        end
        else if (bad_arg)
        begin
            push_cmd.verdict = VERDICT_BAD_ARG;
        end
        else if (!dma_ok)
        begin
            push_cmd.verdict = VERDICT_BAD_DMA;
        end
        else
        begin
            push_cmd.verdict = VERDICT_OK;
        end
        case (req_type)
            REQ_SUBMIT:
            begin
                push_cmd.op = OP_SUBMIT;
            end
            REQ_PROCESS:
            begin
                push_cmd.op = OP_PROCESS;
            end
            REQ_COMPLETE:
            begin
                push_cmd.op     = OP_IRQ;
                push_cmd.events = EV_COMPLETE;
            end
            REQ_ERROR:
            begin
                push_cmd.op     = OP_IRQ;
                push_cmd.events = EV_ERROR;
            end
            REQ_ABORT:
            begin
                push_cmd.op     = OP_IRQ;
                push_cmd.events = EV_ABORT;
            end
            default:
            begin
                push_cmd.op = OP_OTHER;
            end
        endcase
    end

endmodule

/* design/sts_cmd_queue.sv */
// Two-entry command queue between the front end and the executor.
module sts_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sts_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output sts_pkg::cmd_t pop_cmd
);
    import sts_pkg::*;

    localparam int PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int FILL_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t              slot_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(CMDQ_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/sts_back.sv */
// Executor: owns the transfer queue and active transfer and emits result words.
module sts_back #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  sts_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sts_pkg::rsp_t rsp
);
    import sts_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] PH_MAIN  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_FAIL  = 2'd2;

    qent_t             mem [QUEUE_DEPTH];
    qent_t             rd_data_reg;
    logic              mem_we;
    qent_t             mem_wdata;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              active_reg;
    logic              active_next;
    logic [7:0]        act_tag_reg;
    logic [7:0]        act_tag_next;
    logic [31:0]       act_tmo_reg;
    logic [31:0]       act_tmo_next;
    logic [31:0]       act_start_reg;
    logic [31:0]       act_start_next;
    logic              abort_reg;
    logic              abort_next;
    logic [2:0]        events_reg;
    logic [2:0]        events_next;
    logic              cs_reg;
    logic              cs_next;
    logic [31:0]       cnt_reg [CNT_NUM];
    logic [31:0]       cnt_next [CNT_NUM];
    logic [31:0]       now_reg;
    logic [31:0]       now_next;
    logic [1:0]        st_reg;
    logic [1:0]        st_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              res;
    logic              emit;

    logic              out_free;
    logic              ev_hit;
    logic [1:0]        ev_fin;
    logic [2:0]        ev_err;
    logic [1:0]        ev_idx;
    logic [31:0]       elapsed;
    logic              tmo_hit;
    logic              tmo_end;
    logic              active_left;
    logic              will_start;

    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign ev_hit      = active_reg && (events_reg != EV_NONE) &&
                         (!abort_reg || ((events_reg & EV_ABORT) != EV_NONE));
    assign ev_fin      = abort_reg ? FIN_TIMED_OUT :
                         ((events_reg & (EV_ERROR | EV_ABORT)) != EV_NONE) ? FIN_FAILED :
                         FIN_COMPLETED;
    assign ev_err      = (ev_fin == FIN_TIMED_OUT) ? ERR_TIMEOUT :
                         (ev_fin == FIN_FAILED) ? ERR_HAL : ERR_NONE;
    assign ev_idx      = ev_fin - 2'd1;
    assign elapsed     = cmd.now_time - act_start_reg;
    assign tmo_hit     = active_reg && !ev_hit && !abort_reg && (elapsed >= act_tmo_reg);
    assign tmo_end     = tmo_hit && !cmd.abort_ok;
    assign active_left = active_reg && !ev_hit && !tmo_end;
    assign will_start  = !active_left && (count_reg != '0);

    assign mem_wdata.tag     = cmd.tag;
    assign mem_wdata.size    = cmd.size;
    assign mem_wdata.timeout = cmd.timeout;

    always_comb
    begin
        phase_next     = phase_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        act_tag_next   = act_tag_reg;
        act_tmo_next   = act_tmo_reg;
        act_start_next = act_start_reg;
        abort_next     = abort_reg;
        events_next    = events_reg;
        cs_next        = cs_reg;
        now_next       = now_reg;
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        emit           = 1'b0;
        res            = '0;
        case (phase_reg)
            PH_MAIN:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    emit    = 1'b1;
                    res.last = 1'b1;
                    res.kind = KIND_STATUS;
                    res.tag  = active_reg ? act_tag_reg : 8'd0;
                    case (cmd.op)
                        OP_SUBMIT:
                        begin
                            res.kind = KIND_SUBMIT;
                            res.tag  = cmd.tag;
                            case (cmd.verdict)
                                VERDICT_BAD_ARG:
                                begin
                                    res.final_status = FIN_FAILED;
                                    res.error_code   = ERR_BAD_ARG;
                                end
                                VERDICT_BAD_DMA:
                                begin
                                    res.final_status = FIN_FAILED;
                                    res.error_code   = ERR_BAD_DMA;
                                end
                                VERDICT_OK:
                                begin
                                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                                    begin
                                        cnt_next[CNT_REJECTED] = cnt_reg[CNT_REJECTED] + 32'd1;
                                    end
                                    else
                                    begin
                                        mem_we       = 1'b1;
                                        tail_next    = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                                       '0 : tail_reg + 1'b1;
                                        count_next   = count_reg + 1'b1;
                                        res.accepted = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    res.final_status = FIN_NONE;
                                end
                            endcase
                        end
                        OP_PROCESS:
                        begin
                            events_next = EV_NONE;
                            if (ev_hit)
                            begin
                                cs_next          = 1'b0;
                                cnt_next[ev_idx] = cnt_reg[ev_idx] + 32'd1;
                                active_next      = 1'b0;
                                abort_next       = 1'b0;
                                res.kind         = KIND_ENDED;
                                res.tag          = act_tag_reg;
                                res.final_status = ev_fin;
                                res.error_code   = ev_err;
                            end
                            else if (tmo_hit)
                            begin
                                cs_next    = 1'b0;
                                abort_next = 1'b1;
                                if (tmo_end)
                                begin
                                    cnt_next[CNT_TIMED_OUT] = cnt_reg[CNT_TIMED_OUT] + 32'd1;
                                    active_next      = 1'b0;
                                    abort_next       = 1'b0;
                                    res.kind         = KIND_ENDED;
                                    res.tag          = act_tag_reg;
                                    res.final_status = FIN_TIMED_OUT;
                                    res.error_code   = ERR_TIMEOUT;
                                end
                            end
                            if (will_start)
                            begin
                                phase_next = PH_START;
                                now_next   = cmd.now_time;
                                st_next    = cmd.start_status;
                                res.last   = 1'b0;
                                emit       = ev_hit || tmo_end;
                            end
                        end
                        OP_IRQ:
                        begin
                            if (active_reg)
                            begin
                                cs_next = 1'b0;
                            end
                            events_next = events_reg | cmd.events;
                        end
                        default:
                        begin
                            res.kind = KIND_STATUS;
                        end
                    endcase
                end
            end
            PH_START:
            begin
                if (out_free)
                begin
                    head_next      = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next     = count_reg - 1'b1;
                    active_next    = 1'b1;
                    act_tag_next   = rd_data_reg.tag;
                    act_tmo_next   = rd_data_reg.timeout;
                    act_start_next = now_reg;
                    abort_next     = 1'b0;
                    cs_next        = 1'b1;
                    emit           = 1'b1;
                    res.kind       = KIND_STARTED;
                    res.tag        = rd_data_reg.tag;
                    res.start_size = rd_data_reg.size;
                    res.last       = (st_reg == START_OK);
                    phase_next     = (st_reg == START_OK) ? PH_MAIN : PH_FAIL;
                end
            end
            PH_FAIL:
            begin
                if (out_free)
                begin
                    cs_next              = 1'b0;
                    cnt_next[CNT_FAILED] = cnt_reg[CNT_FAILED] + 32'd1;
                    active_next          = 1'b0;
                    abort_next           = 1'b0;
                    emit                 = 1'b1;
                    res.kind             = KIND_ENDED;
                    res.tag              = act_tag_reg;
                    res.final_status     = FIN_FAILED;
                    res.error_code       = (st_reg == START_BUSY) ? ERR_BUSY : ERR_HAL;
                    res.last             = 1'b1;
                    phase_next           = PH_MAIN;
                end
            end
            default:
            begin
                phase_next = PH_MAIN;
            end
        endcase
        res.cs_active       = cs_next;
        res.completed_total = cnt_next[CNT_COMPLETED];
        res.failed_total    = cnt_next[CNT_FAILED];
        res.timed_out_total = cnt_next[CNT_TIMED_OUT];
        res.rejected_total  = cnt_next[CNT_REJECTED];
        rsp_valid_next      = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAIN;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            act_tag_reg   <= '0;
            act_tmo_reg   <= '0;
            act_start_reg <= '0;
            abort_reg     <= 1'b0;
            events_reg    <= EV_NONE;
            cs_reg        <= 1'b0;
            cnt_reg       <= '{default: '0};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            act_tag_reg   <= act_tag_next;
            act_tmo_reg   <= act_tmo_next;
            act_start_reg <= act_start_next;
            abort_reg     <= abort_next;
            events_reg    <= events_next;
            cs_reg        <= cs_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        st_reg  <= st_next;
        if (emit)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[head_reg];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* design/spi_transfer_sequencer.sv */
// Top level of the SPI transfer sequencer.
// The sequencer validates submitted SPI transfers, queues up to QUEUE_DEPTH of them
// and runs them one at a time under control of process ticks and interrupt words.
// Every request word yields one to three result words, and the last one carries
// is_last. A request word passes the classifying front end in its accept cycle and
// waits in a two-entry command queue, and the executor hands out its result words.
// A submit, interrupt or quiet tick yields one word; a tick that ends and starts
// transfers yields the ended word, the started word and, if the start is refused,
// a failed ended word. A tick that starts a transfer without ending one emits no
// word until the registered read of the transfer queue memory is done. The result
// register lets the executor hand over a word in the cycle the previous one is
// taken, and the command queue keeps accepting up to two words while results wait.
module spi_transfer_sequencer #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  tag,
    input  logic        item_idle,
    input  logic        tx_present,
    input  logic        rx_present,
    input  logic [15:0] xfer_size,
    input  logic [31:0] timeout_limit,
    input  logic        cs_valid,
    input  logic        dma_ok,
    input  logic [31:0] now_time,
    input  logic [1:0]  start_status,
    input  logic        abort_ok,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  result_kind,
    output logic        is_last,
    output logic [7:0]  result_tag,
    output logic        accepted,
    output logic [1:0]  final_status,
    output logic [2:0]  error_code,
    output logic [15:0] start_size,
    output logic        cs_active,
    output logic [31:0] completed_total,
    output logic [31:0] failed_total,
    output logic [31:0] timed_out_total,
    output logic [31:0] rejected_total
);
    import sts_pkg::*;

`include "spi_transfer_sequencer_defines.svh"

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop;
    cmd_t pop_cmd;
    rsp_t rsp;

    sts_front u_front (
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .tag           (tag),
        .item_idle     (item_idle),
        .tx_present    (tx_present),
        .rx_present    (rx_present),
        .xfer_size     (xfer_size),
        .timeout_limit (timeout_limit),
        .cs_valid      (cs_valid),
        .dma_ok        (dma_ok),
        .now_time      (now_time),
        .start_status  (start_status),
        .abort_ok      (abort_ok),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    sts_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    sts_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign result_kind     = rsp.kind;
    assign is_last         = rsp.last;
    assign result_tag      = rsp.tag;
    assign accepted        = rsp.accepted;
    assign final_status    = rsp.final_status;
    assign error_code      = rsp.error_code;
    assign start_size      = rsp.start_size;
    assign cs_active       = rsp.cs_active;
    assign completed_total = rsp.completed_total;
    assign failed_total    = rsp.failed_total;
    assign timed_out_total = rsp.timed_out_total;
    assign rejected_total  = rsp.rejected_total;

    `STS_ASSERT_NOW(a_submit_single, rsp_valid && (result_kind == KIND_SUBMIT), is_last, "Submit answer is not the last word.")
    `STS_ASSERT_NOW(a_started_cs, rsp_valid && (result_kind == KIND_STARTED), cs_active && (start_size != 16'd0), "Started word lacks chip select or size.")
    `STS_ASSERT_NOW(a_ended_cs, rsp_valid && (result_kind == KIND_ENDED), !cs_active && (final_status != FIN_NONE), "Ended word keeps chip select or has no outcome.")
    `STS_ASSERT_NEXT(a_refused_start, rsp_valid && rsp_ready && (result_kind == KIND_STARTED) && !is_last, rsp_valid && (result_kind == KIND_ENDED) && (final_status == FIN_FAILED), "Refused start is not followed by a failed end.")

endmodule

/* bench/spi_transfer_sequencer_test.sv */
// Self-checking testbench for the SPI transfer sequencer, with directed rows and random words.
module spi_transfer_sequencer_test;
    import sts_pkg::*;

    localparam int         QDEPTH      = 8;
    localparam logic [2:0] REQ_UNUSED  = 3'd5;
    localparam logic [1:0] START_FAULT = 2'd2;

    typedef struct {
        logic [2:0]  rt;
        logic [7:0]  tag;
        logic        idle;
        logic        tx;
        logic        rx;
        logic [15:0] size;
        logic [31:0] tmo;
        logic        cs;
        logic        dma;
        logic [31:0] now;
        logic [1:0]  st;
        logic        ab;
    } req_word_t;

    typedef struct {
        req_word_t   w;
        bit          typed;
        logic [1:0]  kind;
        logic [1:0]  fin;
        logic [2:0]  err;
    } dir_row_t;

    typedef struct {
        logic [7:0]  tag;
        logic [15:0] size;
        logic [31:0] tmo;
    } slot_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  req_type = '0;
    logic [7:0]  tag = '0;
    logic        item_idle = 1'b0;
    logic        tx_present = 1'b0;
    logic        rx_present = 1'b0;
    logic [15:0] xfer_size = '0;
    logic [31:0] timeout_limit = '0;
    logic        cs_valid = 1'b0;
    logic        dma_ok = 1'b0;
    logic [31:0] now_time = '0;
    logic [1:0]  start_status = '0;
    logic        abort_ok = 1'b0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [1:0]  result_kind;
    logic        is_last;
    logic [7:0]  result_tag;
    logic        accepted;
    logic [1:0]  final_status;
    logic [2:0]  error_code;
    logic [15:0] start_size;
    logic        cs_active;
    logic [31:0] completed_total;
    logic [31:0] failed_total;
    logic [31:0] timed_out_total;
    logic [31:0] rejected_total;

    spi_transfer_sequencer #(.QUEUE_DEPTH(QDEPTH)) u_dut (.*);

    slot_t        slots [0:QDEPTH-1];
    int unsigned  head = 0;
    int unsigned  tail = 0;
    int unsigned  count = 0;
    bit           act_on = 1'b0;
    logic [7:0]   act_tag = '0;
    logic [31:0]  act_tmo = '0;
    logic [31:0]  act_t0 = '0;
    bit           aborting = 1'b0;
    logic [2:0]   ev = EV_NONE;
    bit           cs_on = 1'b0;
    logic [31:0]  totals [0:3] = '{default: '0};

    rsp_t         step_results[$];
    rsp_t         pending_results[$];
    dir_row_t     rows[$];
    int           mismatches = 0;
    int           words_seen = 0;
    int           burst_left = 0;
    logic [31:0]  ms_clock = 32'hFFFF_FF00;

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("** spi_transfer_sequencer: FAILED **");
        $finish;
    end

    function automatic void note(input logic [1:0] kind, input logic [7:0] t, input logic acc,
                                 input logic [1:0] fin, input logic [2:0] err,
                                 input logic [15:0] size);
        rsp_t r;
        r.kind = kind;
        r.last = 1'b0;
        r.tag = t;
        r.accepted = acc;
        r.final_status = fin;
        r.error_code = err;
        r.start_size = size;
        r.cs_active = cs_on;
        r.completed_total = totals[CNT_COMPLETED];
        r.failed_total = totals[CNT_FAILED];
        r.timed_out_total = totals[CNT_TIMED_OUT];
        r.rejected_total = totals[CNT_REJECTED];
        step_results.push_back(r);
    endfunction

    function automatic void note_status();
        note(KIND_STATUS, act_on ? act_tag : 8'd0, 1'b0, FIN_NONE, ERR_NONE, 16'd0);
    endfunction

    function automatic void finish_transfer(input logic [1:0] fin, input logic [2:0] err);
        if (act_on)
        begin
            cs_on = 1'b0;
            totals[fin - FIN_COMPLETED] = totals[fin - FIN_COMPLETED] + 32'd1;
            act_on = 1'b0;
            aborting = 1'b0;
            note(KIND_ENDED, act_tag, 1'b0, fin, err, 16'd0);
        end
    endfunction

    function automatic void apply_request(input req_word_t w);
        logic [2:0]  ev_now;
        logic [31:0] elapsed;
        slot_t       s;
        rsp_t        r;
        step_results.delete();
        case (w.rt)
            REQ_SUBMIT:
            begin
                if (!w.idle)
                    note(KIND_SUBMIT, w.tag, 1'b0, FIN_NONE, ERR_NONE, 16'd0);
                else if (!w.tx || !w.rx || w.size == 0 || w.tmo == 0 || !w.cs)
                    note(KIND_SUBMIT, w.tag, 1'b0, FIN_FAILED, ERR_BAD_ARG, 16'd0);
                else if (!w.dma)
                    note(KIND_SUBMIT, w.tag, 1'b0, FIN_FAILED, ERR_BAD_DMA, 16'd0);
                else if (count >= QDEPTH)
                begin
                    totals[CNT_REJECTED] = totals[CNT_REJECTED] + 32'd1;
                    note(KIND_SUBMIT, w.tag, 1'b0, FIN_NONE, ERR_NONE, 16'd0);
                end
                else
                begin
                    s.tag = w.tag;
                    s.size = w.size;
                    s.tmo = w.tmo;
                    slots[tail] = s;
                    tail = (tail + 1) % QDEPTH;
                    count++;
                    note(KIND_SUBMIT, w.tag, 1'b1, FIN_NONE, ERR_NONE, 16'd0);
                end
            end
            REQ_PROCESS:
            begin
                ev_now = ev;
                ev = EV_NONE;
                if (act_on && ev_now != EV_NONE)
                begin
                    if (aborting)
                    begin
                        if ((ev_now & EV_ABORT) != EV_NONE)
                            finish_transfer(FIN_TIMED_OUT, ERR_TIMEOUT);
                    end
                    else if ((ev_now & (EV_ERROR | EV_ABORT)) != EV_NONE)
                        finish_transfer(FIN_FAILED, ERR_HAL);
                    else if ((ev_now & EV_COMPLETE) != EV_NONE)
                        finish_transfer(FIN_COMPLETED, ERR_NONE);
                end
                elapsed = w.now - act_t0;
                if (act_on && !aborting && elapsed >= act_tmo)
                begin
                    cs_on = 1'b0;
                    aborting = 1'b1;
                    if (!w.ab)
                        finish_transfer(FIN_TIMED_OUT, ERR_TIMEOUT);
                end
                if (!act_on && count > 0)
                begin
                    s = slots[head];
                    head = (head + 1) % QDEPTH;
                    count--;
                    act_on = 1'b1;
                    act_tag = s.tag;
                    act_tmo = s.tmo;
                    act_t0 = w.now;
                    aborting = 1'b0;
                    cs_on = 1'b1;
                    note(KIND_STARTED, s.tag, 1'b0, FIN_NONE, ERR_NONE, s.size);
                    if (w.st != START_OK)
                        finish_transfer(FIN_FAILED, w.st == START_BUSY ? ERR_BUSY : ERR_HAL);
                end
                if (step_results.size() == 0)
                    note_status();
            end
            REQ_COMPLETE, REQ_ERROR, REQ_ABORT:
            begin
                if (act_on)
                    cs_on = 1'b0;
                ev = ev | ((w.rt == REQ_COMPLETE) ? EV_COMPLETE :
                           (w.rt == REQ_ERROR) ? EV_ERROR : EV_ABORT);
                note_status();
            end
            default:
                note_status();
        endcase
        r = step_results[step_results.size() - 1];
        r.last = 1'b1;
        step_results[step_results.size() - 1] = r;
        foreach (step_results[j])
            pending_results.push_back(step_results[j]);
    endfunction

    function automatic req_word_t submit_word(input logic [7:0] t, input logic idle,
                                              input logic tx, input logic rx,
                                              input logic cs, input logic dma,
                                              input logic [15:0] size, input logic [31:0] tmo);
        req_word_t w;
        w = '{rt: REQ_SUBMIT, tag: t, idle: idle, tx: tx, rx: rx, size: size, tmo: tmo,
              cs: cs, dma: dma, now: '0, st: START_OK, ab: 1'b0};
        return w;
    endfunction

    function automatic req_word_t control_word(input logic [2:0] rt, input logic [31:0] now,
                                               input logic [1:0] st, input logic ab);
        req_word_t w;
        w = '{rt: rt, tag: '0, idle: 1'b0, tx: 1'b0, rx: 1'b0, size: '0, tmo: '0,
              cs: 1'b0, dma: 1'b0, now: now, st: st, ab: ab};
        return w;
    endfunction

    function automatic dir_row_t plain_row(input req_word_t w);
        dir_row_t d;
        d = '{w: w, typed: 1'b0, kind: KIND_STATUS, fin: FIN_NONE, err: ERR_NONE};
        return d;
    endfunction

    function automatic dir_row_t typed_row(input req_word_t w, input logic [1:0] kind,
                                           input logic [1:0] fin, input logic [2:0] err);
        dir_row_t d;
        d = '{w: w, typed: 1'b1, kind: kind, fin: fin, err: err};
        return d;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        rsp_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t unexpected result word: expected none, got kind %0d tag %0h",
                     $time, result_kind, result_tag);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            cmp_field("result_kind", 32'(want.kind), 32'(result_kind));
            cmp_field("is_last", 32'(want.last), 32'(is_last));
            cmp_field("result_tag", 32'(want.tag), 32'(result_tag));
            cmp_field("accepted", 32'(want.accepted), 32'(accepted));
            cmp_field("final_status", 32'(want.final_status), 32'(final_status));
            cmp_field("error_code", 32'(want.error_code), 32'(error_code));
            cmp_field("start_size", 32'(want.start_size), 32'(start_size));
            cmp_field("cs_active", 32'(want.cs_active), 32'(cs_active));
            cmp_field("completed_total", want.completed_total, completed_total);
            cmp_field("failed_total", want.failed_total, failed_total);
            cmp_field("timed_out_total", want.timed_out_total, timed_out_total);
            cmp_field("rejected_total", want.rejected_total, rejected_total);
        end
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic send_word(input req_word_t w);
        req_valid <= 1'b1;
        req_type <= w.rt;
        tag <= w.tag;
        item_idle <= w.idle;
        tx_present <= w.tx;
        rx_present <= w.rx;
        xfer_size <= w.size;
        timeout_limit <= w.tmo;
        cs_valid <= w.cs;
        dma_ok <= w.dma;
        now_time <= w.now;
        start_status <= w.st;
        abort_ok <= w.ab;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        apply_request(w);
    endtask

    initial begin
        int cyc;
        int mode;
        int hold;
        bit held;
        cyc = 0;
        mode = 0;
        hold = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                check_word();
                words_seen++;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ready <= 1'b0;
            end
            else if (!held && words_seen >= 40)
            begin
                held = 1'b1;
                hold = 80;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (cyc % 48 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= 1'($urandom_range(0, 1));
                    2: rsp_ready <= (cyc % 3 == 0);
                    default: rsp_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
            cyc++;
        end
    end

    initial begin
        int          i;
        int          n;
        int          pick;
        int          sel;
        req_word_t   w;
        rsp_t        r;

        rows.push_back(typed_row(control_word(REQ_UNUSED, 32'd0, START_OK, 1'b0),
                                 KIND_STATUS, FIN_NONE, ERR_NONE));
        rows.push_back(typed_row(submit_word(8'h11, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'd4, 32'd9),
                                 KIND_SUBMIT, FIN_NONE, ERR_NONE));
        rows.push_back(typed_row(submit_word(8'h12, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 16'd4, 32'd9),
                                 KIND_SUBMIT, FIN_FAILED, ERR_BAD_ARG));
        rows.push_back(typed_row(submit_word(8'h13, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'd4, 32'd9),
                                 KIND_SUBMIT, FIN_FAILED, ERR_BAD_ARG));
        rows.push_back(typed_row(submit_word(8'h14, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 32'd9),
                                 KIND_SUBMIT, FIN_FAILED, ERR_BAD_ARG));
        rows.push_back(typed_row(submit_word(8'h15, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd4, 32'd0),
                                 KIND_SUBMIT, FIN_FAILED, ERR_BAD_ARG));
        rows.push_back(typed_row(submit_word(8'h16, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 16'd4, 32'd9),
                                 KIND_SUBMIT, FIN_FAILED, ERR_BAD_ARG));
        rows.push_back(typed_row(submit_word(8'h17, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'd4, 32'd9),
                                 KIND_SUBMIT, FIN_FAILED, ERR_BAD_DMA));
        rows.push_back(typed_row(control_word(REQ_PROCESS, 32'd0, START_OK, 1'b0),
                                 KIND_STATUS, FIN_NONE, ERR_NONE));
        rows.push_back(typed_row(control_word(REQ_COMPLETE, 32'd0, START_OK, 1'b0),
                                 KIND_STATUS, FIN_NONE, ERR_NONE));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'd1, START_OK, 1'b0)));
        rows.push_back(plain_row(submit_word(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                             16'hFFFF, 32'hFFFF_FFFF)));
        rows.push_back(plain_row(submit_word(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd1, 32'd1)));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'd100, START_OK, 1'b0)));
        rows.push_back(plain_row(control_word(REQ_COMPLETE, 32'd0, START_OK, 1'b0)));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'd101, START_OK, 1'b0)));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'd102, START_OK, 1'b1)));
        rows.push_back(plain_row(control_word(REQ_ERROR, 32'd0, START_OK, 1'b0)));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'd103, START_OK, 1'b1)));
        rows.push_back(plain_row(control_word(REQ_ABORT, 32'd0, START_OK, 1'b0)));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'd104, START_OK, 1'b1)));
        rows.push_back(plain_row(submit_word(8'h5A, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'd3, 32'd2)));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'hFFFF_FFFF, START_BUSY, 1'b0)));
        rows.push_back(plain_row(submit_word(8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                             16'h8000, 32'd1)));
        rows.push_back(plain_row(control_word(REQ_PROCESS, 32'd0, START_FAULT, 1'b0)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[k])
        begin
            pace();
            send_word(rows[k].w);
            if (rows[k].typed)
            begin
                n = pending_results.size() - 1;
                r = pending_results[n];
                r.kind = rows[k].kind;
                r.final_status = rows[k].fin;
                r.error_code = rows[k].err;
                pending_results[n] = r;
            end
        end

        for (i = 0; i < 95; i++)
        begin
            w.rt = REQ_UNUSED;
            w.tag = 8'($urandom);
            w.idle = 1'($urandom);
            w.tx = 1'($urandom);
            w.rx = 1'($urandom);
            w.size = 16'($urandom);
            w.tmo = $urandom;
            w.cs = 1'($urandom);
            w.dma = 1'($urandom);
            w.now = $urandom;
            w.st = 2'($urandom_range(0, 2));
            w.ab = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (i < 11 || pick < 25)
            begin
                w.rt = REQ_SUBMIT;
                w.idle = 1'b1;
                w.tx = 1'b1;
                w.rx = 1'b1;
                w.cs = 1'b1;
                w.dma = 1'b1;
                w.size = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 16));
                sel = $urandom_range(0, 9);
                if (sel < 8)
                    w.tmo = $urandom_range(1, 12);
                else if (sel == 8)
                    w.tmo = 32'hFFFF_FFFF;
                else if (w.tmo == 0)
                    w.tmo = 32'd1;
            end
            else if (pick < 33)
            begin
                w.rt = REQ_SUBMIT;
                if ($urandom_range(0, 3) == 0)
                    w.size = '0;
                if ($urandom_range(0, 3) == 0)
                    w.tmo = '0;
            end
            else if (pick < 68)
            begin
                w.rt = REQ_PROCESS;
                if ($urandom_range(0, 19) == 0)
                    ms_clock = $urandom;
                else
                    ms_clock = ms_clock + $urandom_range(0, 3);
                w.now = ms_clock;
                sel = $urandom_range(0, 9);
                w.st = (sel == 0) ? START_BUSY : (sel == 1) ? START_FAULT : START_OK;
            end
            else if (pick < 95)
            begin
                sel = $urandom_range(0, 9);
                w.rt = (sel < 6) ? REQ_COMPLETE : (sel < 8) ? REQ_ERROR : REQ_ABORT;
            end
            else
                w.rt = 3'($urandom_range(5, 7));

            if (i == 70)
            begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            pace();
            send_word(w);
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("** spi_transfer_sequencer: PASSED **");
        else
            $display("** spi_transfer_sequencer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/sts_pkg.sv
design/sts_front.sv
design/sts_cmd_queue.sv
design/sts_back.sv
design/spi_transfer_sequencer.sv
bench/spi_transfer_sequencer_test.sv
